FILE: rtl/assert_macros.svh
// Assertion helpers shared by the parser and output buffer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checks a property on every rising clock edge outside of reset.
`define ASSERT_CHK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// Checks that a condition never holds outside of reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CHK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

FILE: rtl/h3sp_pkg.sv
package h3sp_pkg;

    localparam int VAL_W    = 62;
    localparam int BYTE_W   = 8;
    localparam int LEFT_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int TDATA_W  = 192;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_CAPACITY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTION_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKED_STREAMS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CONNECT         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DATAGRAM        = 3'd4;

    // Input word kinds.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Setting identifiers.
    localparam logic [VAL_W-1:0] ID_TABLE_CAPACITY  = 62'h01;
    localparam logic [VAL_W-1:0] ID_SECTION_LIMIT   = 62'h06;
    localparam logic [VAL_W-1:0] ID_BLOCKED_STREAMS = 62'h07;
    localparam logic [VAL_W-1:0] ID_CONNECT         = 62'h08;
    localparam logic [VAL_W-1:0] ID_DATAGRAM        = 62'h33;

    typedef enum logic [2:0] {
        TGT_NONE     = 3'd0,
        TGT_CAPACITY = 3'd1,
        TGT_LIMIT    = 3'd2,
        TGT_BLOCKED  = 3'd3,
        TGT_CONNECT  = 3'd4,
        TGT_DATAGRAM = 3'd5
    } t_target;

    typedef struct packed {
        logic [VAL_W-1:0] table_capacity;
        logic [VAL_W-1:0] section_limit;
        logic [VAL_W-1:0] blocked_streams;
        logic             connect_enabled;
        logic             datagram_enabled;
    } t_settings;

    typedef struct packed {
        t_settings settings;
        logic      parse_error;
    } t_result;

    function automatic t_target target_of(input logic [VAL_W-1:0] id);
        t_target tgt;
        case (id)
            ID_TABLE_CAPACITY:  tgt = TGT_CAPACITY;
            ID_SECTION_LIMIT:   tgt = TGT_LIMIT;
            ID_BLOCKED_STREAMS: tgt = TGT_BLOCKED;
            ID_CONNECT:         tgt = TGT_CONNECT;
            ID_DATAGRAM:        tgt = TGT_DATAGRAM;
            default:            tgt = TGT_NONE;
        endcase
        return tgt;
    endfunction

endpackage

FILE: rtl/h3_settings_payload_parser.sv
// Channel   | Dir | Word                      | Fields (lowest bit up)
// s_axis    | in  | one payload byte or end   | tdata: data_byte; tuser: kind
// m_axis    | out | decoded settings          | tdata: five settings, zero fill; tuser: parse_error
// cfg       | in  | default setting write     | idx 0..4, data up to 62 bits
//
// One input word is taken per cycle, bytes and end words alike, while no end word
// waits in the input register; the parse step for a word is combinational logic
// between the input register and the parser state. An end word's result enters a
// two-entry output buffer after the input register; an end word waits in the input
// register only while both buffer entries are full. Reset is synchronous and active
// low, and clears the defaults to zero, the parser and the sticky error.
module h3_settings_payload_parser (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [h3sp_pkg::BYTE_W-1:0]        i_s_axis_tdata,   // data_byte
    input  logic                               i_s_axis_tuser,   // kind
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // table_capacity, section_limit, blocked_streams, connect_enabled,
    // datagram_enabled, zero fill
    output logic [h3sp_pkg::TDATA_W-1:0]       o_m_axis_tdata,
    output logic                               o_m_axis_tuser,   // parse_error
    input  logic                               i_cfg_we,
    input  logic [h3sp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [h3sp_pkg::VAL_W-1:0]         i_cfg_data
);

    h3sp_pkg::t_settings w_defaults;
    logic                w_push;
    logic                w_push_ok;
    h3sp_pkg::t_result   w_result;
    h3sp_pkg::t_result   w_out;

    h3sp_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_defaults (w_defaults)
    );

    h3sp_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_kind     (i_s_axis_tuser),
        .i_byte     (i_s_axis_tdata),
        .i_defaults (w_defaults),
        .i_push_ok  (w_push_ok),
        .o_push     (w_push),
        .o_result   (w_result)
    );

    h3sp_out_buf u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_data    (w_result),
        .o_push_ok (w_push_ok),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_data    (w_out)
    );

    assign o_m_axis_tdata = {4'b0000,
                             w_out.settings.datagram_enabled,
                             w_out.settings.connect_enabled,
                             w_out.settings.blocked_streams,
                             w_out.settings.section_limit,
                             w_out.settings.table_capacity};
    assign o_m_axis_tuser = w_out.parse_error;

endmodule

FILE: rtl/h3sp_cfg_regs.sv
module h3sp_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [h3sp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [h3sp_pkg::VAL_W-1:0]        i_cfg_data,
    output h3sp_pkg::t_settings               o_defaults
);

    h3sp_pkg::t_settings r_defaults;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_defaults <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                h3sp_pkg::CFG_TABLE_CAPACITY:  r_defaults.table_capacity  <= i_cfg_data;
                h3sp_pkg::CFG_SECTION_LIMIT:   r_defaults.section_limit   <= i_cfg_data;
                h3sp_pkg::CFG_BLOCKED_STREAMS: r_defaults.blocked_streams <= i_cfg_data;
                h3sp_pkg::CFG_CONNECT:         r_defaults.connect_enabled <= i_cfg_data[0];
                h3sp_pkg::CFG_DATAGRAM:        r_defaults.datagram_enabled <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_defaults = r_defaults;

endmodule

FILE: rtl/h3sp_parse.sv
`include "assert_macros.svh"

module h3sp_parse (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_kind,
    input  logic [h3sp_pkg::BYTE_W-1:0]     i_byte,
    input  h3sp_pkg::t_settings             i_defaults,
    input  logic                            i_push_ok,
    output logic                            o_push,
    output h3sp_pkg::t_result               o_result
);

    // Input register.
    logic                        r_in_valid;
    logic                        r_in_kind;
    logic [h3sp_pkg::BYTE_W-1:0] r_in_byte;

    // Parser state.
    logic                        r_started, n_started;
    logic                        r_expect, n_expect;
    logic [h3sp_pkg::LEFT_W-1:0] r_left, n_left;
    logic [h3sp_pkg::VAL_W-1:0]  r_acc, n_acc;
    h3sp_pkg::t_target           r_target, n_target;
    logic                        r_err, n_err;
    h3sp_pkg::t_settings         r_work, n_work;

    logic                        w_take;
    logic                        w_end_err;
    h3sp_pkg::t_settings         w_base;
    logic [h3sp_pkg::LEFT_W-1:0] w_left;
    logic [h3sp_pkg::VAL_W-1:0]  w_acc;
    logic                        n_push;
    h3sp_pkg::t_result           n_result;

    // A byte is always consumed; an end word needs room in the output buffer.
    assign w_take  = r_in_valid && ((r_in_kind == h3sp_pkg::KIND_BYTE) || i_push_ok);
    assign o_ready = !r_in_valid || w_take;

    // The working copies take the defaults on the first byte of a payload.
    assign w_base    = r_started ? r_work : i_defaults;
    assign w_end_err = r_err || (r_left != '0) || r_expect;

    always_comb begin
        if (r_left == '0) begin
            w_left = h3sp_pkg::LEFT_W'((4'd1 << r_in_byte[7:6]) - 4'd1);
            w_acc  = {{(h3sp_pkg::VAL_W-6){1'b0}}, r_in_byte[5:0]};
        end else begin
            w_left = r_left - 3'd1;
            w_acc  = {r_acc[h3sp_pkg::VAL_W-h3sp_pkg::BYTE_W-1:0], r_in_byte};
        end
    end

    always_comb begin
        n_started = r_started;
        n_expect  = r_expect;
        n_left    = r_left;
        n_acc     = r_acc;
        n_target  = r_target;
        n_err     = r_err;
        n_work    = r_work;
        n_push    = 1'b0;
        n_result  = '0;
        if (w_take) begin
            if (r_in_kind == h3sp_pkg::KIND_BYTE) begin
                if (!r_err) begin
                    n_started = 1'b1;
                    n_work    = w_base;
                    n_left    = w_left;
                    n_acc     = w_acc;
                    if (w_left == '0) begin
                        n_acc = '0;
                        if (!r_expect) begin
                            n_target = h3sp_pkg::target_of(w_acc);
                            n_expect = 1'b1;
                        end else begin
                            n_expect = 1'b0;
                            n_target = h3sp_pkg::TGT_NONE;
                            case (r_target)
                                h3sp_pkg::TGT_CAPACITY: n_work.table_capacity  = w_acc;
                                h3sp_pkg::TGT_LIMIT:    n_work.section_limit   = w_acc;
                                h3sp_pkg::TGT_BLOCKED:  n_work.blocked_streams = w_acc;
                                h3sp_pkg::TGT_CONNECT:  n_work.connect_enabled = (w_acc != '0);
                                h3sp_pkg::TGT_DATAGRAM: n_work.datagram_enabled = (w_acc != '0);
                                default: begin
                                end
                            endcase
                        end
                    end
                end
            end else begin
                n_push               = 1'b1;
                n_err                = w_end_err;
                n_result.parse_error = w_end_err;
                n_result.settings    = w_end_err ? '0 : w_base;
                n_started            = 1'b0;
                n_expect             = 1'b0;
                n_left               = '0;
                n_acc                = '0;
                n_target             = h3sp_pkg::TGT_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_started  <= 1'b0;
            r_expect   <= 1'b0;
            r_left     <= '0;
            r_acc      <= '0;
            r_target   <= h3sp_pkg::TGT_NONE;
            r_err      <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            r_started <= n_started;
            r_expect  <= n_expect;
            r_left    <= n_left;
            r_acc     <= n_acc;
            r_target  <= n_target;
            r_err     <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_kind <= i_kind;
            r_in_byte <= i_byte;
        end
        r_work <= n_work;
    end

    assign o_push   = n_push;
    assign o_result = n_result;

    // Once an error is seen, only a reset clears it.
    `ASSERT_CHK(a_err_sticky, i_clk, i_rst_n, r_err |=> r_err)
    // An integer in progress or an open pair means a payload has started.
    `ASSERT_CHK(a_busy_started, i_clk, i_rst_n, ((r_left != '0) || r_expect) |-> r_started)
    // Between integers the accumulator is empty.
    `ASSERT_CHK(a_acc_clear, i_clk, i_rst_n, (r_left == '0) |-> (r_acc == '0))
    // A result is only pushed when the output buffer has room.
    `ASSERT_NEVER(a_push_full, i_clk, i_rst_n, o_push && !i_push_ok)

endmodule

FILE: rtl/h3sp_out_buf.sv
`include "assert_macros.svh"

module h3sp_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  h3sp_pkg::t_result   i_data,
    output logic                o_push_ok,
    output logic                o_valid,
    input  logic                i_ready,
    output h3sp_pkg::t_result   o_data
);

    logic              r_main_valid;
    logic              r_skid_valid;
    h3sp_pkg::t_result r_main;
    h3sp_pkg::t_result r_skid;
    logic              w_drain;

    assign w_drain   = !r_main_valid || i_ready;
    assign o_push_ok = !r_skid_valid;
    assign o_valid   = r_main_valid;
    assign o_data    = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_drain) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= i_push;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_drain) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
                if (i_push) begin
                    r_skid <= i_data;
                end
            end else begin
                r_main <= i_data;
            end
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    // The spare entry only fills behind a waiting word.
    `ASSERT_CHK(a_skid_behind_main, i_clk, i_rst_n, r_skid_valid |-> r_main_valid)
    // A full spare entry drains into the main register when the sink takes a word.
    `ASSERT_CHK(a_skid_moves, i_clk, i_rst_n,
                (r_skid_valid && i_ready && !i_push) |=> (r_main_valid && !r_skid_valid))

endmodule

FILE: verif/tb.sv
module tb;
    import h3sp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 190;
    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] data;
    } word_t;

    typedef struct packed {
        logic [VAL_W-1:0] capacity;
        logic [VAL_W-1:0] limit;
        logic [VAL_W-1:0] blocked;
        logic             connect;
        logic             datagram;
        logic             parse_error;
    } settings_t;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_data  = '0;
    logic                 s_kind  = KIND_BYTE;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [TDATA_W-1:0]   m_data;
    logic                 m_user;
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = CFG_TABLE_CAPACITY;
    logic [VAL_W-1:0]     cfg_data = '0;

    h3_settings_payload_parser uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_kind),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Default registers as the block should hold them.
    logic [VAL_W-1:0] dflt_capacity = '0;
    logic [VAL_W-1:0] dflt_limit    = '0;
    logic [VAL_W-1:0] dflt_blocked  = '0;
    logic             dflt_connect  = 1'b0;
    logic             dflt_datagram = 1'b0;

    // Parser state of the predictor.
    logic              want_value  = 1'b0;
    logic [LEFT_W-1:0] bytes_due   = '0;
    logic [VAL_W-1:0]  acc         = '0;
    t_target           pend_target = TGT_NONE;
    logic [VAL_W-1:0]  cur_capacity = '0;
    logic [VAL_W-1:0]  cur_limit    = '0;
    logic [VAL_W-1:0]  cur_blocked  = '0;
    logic              cur_connect  = 1'b0;
    logic              cur_datagram = 1'b0;
    logic              err_sticky   = 1'b0;
    logic              in_payload   = 1'b0;

    word_t     word_queue[$];
    settings_t settings_due[$];

    logic [VAL_W-1:0] known_ids [5] = '{ID_TABLE_CAPACITY, ID_SECTION_LIMIT,
                                        ID_BLOCKED_STREAMS, ID_CONNECT, ID_DATAGRAM};

    bit          send_gaps = 1'b1;
    bit          recv_gaps = 1'b1;
    bit          hold_go   = 1'b0;
    int          errors    = 0;
    int          words_pushed = 0;
    int          cycle_count  = 0;
    int unsigned send_wait = 0;
    int unsigned recv_wait = 0;
    int unsigned hold_left = 0;
    int unsigned draw;
    word_t       next_word;

    function automatic t_target id_to_target(input logic [VAL_W-1:0] id);
        if (id == ID_TABLE_CAPACITY)  return TGT_CAPACITY;
        if (id == ID_SECTION_LIMIT)   return TGT_LIMIT;
        if (id == ID_BLOCKED_STREAMS) return TGT_BLOCKED;
        if (id == ID_CONNECT)         return TGT_CONNECT;
        if (id == ID_DATAGRAM)        return TGT_DATAGRAM;
        return TGT_NONE;
    endfunction

    function automatic void load_working();
        cur_capacity = dflt_capacity;
        cur_limit    = dflt_limit;
        cur_blocked  = dflt_blocked;
        cur_connect  = dflt_connect;
        cur_datagram = dflt_datagram;
    endfunction

    function automatic void store_setting(input logic [VAL_W-1:0] v);
        case (pend_target)
            TGT_CAPACITY: cur_capacity = v;
            TGT_LIMIT:    cur_limit = v;
            TGT_BLOCKED:  cur_blocked = v;
            TGT_CONNECT:  cur_connect = (v != '0);
            TGT_DATAGRAM: cur_datagram = (v != '0);
            default: ;
        endcase
    endfunction

    function automatic void parse_word(input logic kind, input logic [BYTE_W-1:0] b);
        settings_t res;
        if (kind == KIND_BYTE) begin
            if (err_sticky)
                return;
            if (!in_payload) begin
                load_working();
                in_payload = 1'b1;
            end
            if (bytes_due == '0) begin
                bytes_due = LEFT_W'((1 << b[7:6]) - 1);
                acc = VAL_W'(b[5:0]);
            end else begin
                acc = {acc[VAL_W-9:0], b};
                bytes_due = bytes_due - 1'b1;
            end
            if (bytes_due == '0) begin
                if (!want_value) begin
                    pend_target = id_to_target(acc);
                    want_value = 1'b1;
                end else begin
                    store_setting(acc);
                    want_value = 1'b0;
                    pend_target = TGT_NONE;
                end
                acc = '0;
            end
            return;
        end
        // An end inside an integer or after a lone identifier poisons the parser for good.
        if (bytes_due != '0 || want_value)
            err_sticky = 1'b1;
        res = '0;
        if (err_sticky) begin
            res.parse_error = 1'b1;
        end else begin
            if (!in_payload)
                load_working();
            res.capacity = cur_capacity;
            res.limit    = cur_limit;
            res.blocked  = cur_blocked;
            res.connect  = cur_connect;
            res.datagram = cur_datagram;
        end
        want_value  = 1'b0;
        bytes_due   = '0;
        acc         = '0;
        pend_target = TGT_NONE;
        in_payload  = 1'b0;
        settings_due.push_back(res);
    endfunction

    function automatic void check_field(input string name, input logic [VAL_W-1:0] want,
                                        input logic [VAL_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    function automatic void check_settings();
        settings_t want;
        if (settings_due.size() == 0) begin
            $error("settings word with nothing expected: tdata %0h, tuser %0b", m_data, m_user);
            errors++;
            return;
        end
        want = settings_due.pop_front();
        check_field("table_capacity", want.capacity, m_data[VAL_W-1:0]);
        check_field("section_limit", want.limit, m_data[2*VAL_W-1:VAL_W]);
        check_field("blocked_streams", want.blocked, m_data[3*VAL_W-1:2*VAL_W]);
        check_field("connect_enabled", VAL_W'(want.connect), VAL_W'(m_data[3*VAL_W]));
        check_field("datagram_enabled", VAL_W'(want.datagram), VAL_W'(m_data[3*VAL_W+1]));
        check_field("tdata fill", '0, VAL_W'(m_data[TDATA_W-1:3*VAL_W+2]));
        check_field("parse_error", VAL_W'(want.parse_error), VAL_W'(m_user));
    endfunction

    // Input side: one word from the queue at a time, with a random gap after each.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                parse_word(s_kind, s_data);
            if (!s_valid || s_ready) begin
                if (send_wait > 0) begin
                    send_wait <= send_wait - 1;
                    s_valid <= 1'b0;
                end else if (word_queue.size() > 0) begin
                    next_word = word_queue.pop_front();
                    s_valid <= 1'b1;
                    s_kind <= next_word.kind;
                    s_data <= next_word.data;
                    send_wait <= send_gaps ? $urandom_range(0, 6) : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: checks each settings word and stalls at random or for a long hold.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
            recv_wait <= 0;
            hold_left <= 0;
        end else begin
            if (m_valid && m_ready)
                check_settings();
            if (hold_go) begin
                hold_go = 1'b0;
                hold_left <= HOLD_CYCLES;
                recv_wait <= 0;
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
            end else if (m_valid && m_ready) begin
                draw = recv_gaps ? $urandom_range(0, 6) : 0;
                recv_wait <= draw;
                m_ready <= (draw == 0);
            end else if (!m_ready) begin
                if (recv_wait > 1)
                    recv_wait <= recv_wait - 1;
                else
                    m_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic push_word(input logic kind, input logic [BYTE_W-1:0] b);
        word_t w;
        w.kind = kind;
        w.data = b;
        word_queue.push_back(w);
        words_pushed++;
    endtask

    task automatic push_end();
        push_word(KIND_END, BYTE_W'($urandom));
    endtask

    // Emits the top 'keep' bytes of the integer in the given length code.
    task automatic push_varint(input logic [VAL_W-1:0] v, input logic [1:0] code,
                               input int keep = 8);
        int n;
        logic [63:0] enc;
        n = 1 << code;
        enc = {2'b00, v} | (64'(code) << (8 * n - 2));
        for (int i = n - 1; i >= 0 && i >= n - keep; i--)
            push_word(KIND_BYTE, enc[8*i +: 8]);
    endtask

    function automatic logic [1:0] len_code_of(input logic [VAL_W-1:0] v);
        if (v < 62'd64)         return 2'd0;
        if (v < 62'd16384)      return 2'd1;
        if (v < 62'd1073741824) return 2'd2;
        return 2'd3;
    endfunction

    function automatic logic [VAL_W-1:0] rand_fit(input logic [1:0] code);
        logic [VAL_W-1:0] mask;
        logic [VAL_W-1:0] r;
        mask = VAL_MAX >> (VAL_W - (8 << code) + 2);
        r = VAL_W'({$urandom, $urandom});
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return mask;
            2:       return r & 62'h3F;
            default: return r & mask;
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] rand_id();
        if ($urandom_range(0, 9) < 7)
            return known_ids[$urandom_range(0, 4)];
        return rand_fit(2'($urandom_range(0, 3)));
    endfunction

    task automatic push_any(input logic [VAL_W-1:0] v);
        push_varint(v, 2'($urandom_range(len_code_of(v), 3)));
    endtask

    task automatic push_pair();
        push_any(rand_id());
        push_any(rand_fit(2'($urandom_range(0, 3))));
    endtask

    task automatic push_payload();
        repeat ($urandom_range(0, 5))
            push_pair();
        push_end();
    endtask

    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (word_queue.size() != 0 || s_valid || settings_due.size() != 0);
        // Bytes still in the pipe give no result; let them settle.
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_default(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] v);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= v;
        case (idx)
            CFG_TABLE_CAPACITY:  dflt_capacity = v;
            CFG_SECTION_LIMIT:   dflt_limit = v;
            CFG_BLOCKED_STREAMS: dflt_blocked = v;
            CFG_CONNECT:         dflt_connect = v[0];
            CFG_DATAGRAM:        dflt_datagram = v[0];
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic [1:0] code;
        int phase_end;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty payload, every known setting, extremes, long id, unknown id.
        push_end();
        push_varint(ID_TABLE_CAPACITY, 2'd0);
        push_varint(VAL_MAX, 2'd3);
        push_varint(ID_SECTION_LIMIT, 2'd1);
        push_varint(62'h3F, 2'd0);
        push_varint(ID_CONNECT, 2'd0);
        push_varint(62'h2, 2'd2);
        push_varint(ID_DATAGRAM, 2'd0);
        push_varint(62'h1, 2'd0);
        push_varint(ID_BLOCKED_STREAMS, 2'd0);
        push_varint('0, 2'd0);
        push_varint(62'h3F, 2'd0);
        push_varint(62'h5, 2'd0);
        push_end();
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            if (p == 0 || p == PHASES - 1) begin
                write_default(CFG_TABLE_CAPACITY, VAL_MAX);
                write_default(CFG_SECTION_LIMIT, VAL_MAX);
                write_default(CFG_BLOCKED_STREAMS, VAL_MAX);
                write_default(CFG_CONNECT, 62'd1);
                write_default(CFG_DATAGRAM, 62'd1);
            end else if (p == 1) begin
                write_default(CFG_TABLE_CAPACITY, '0);
                write_default(CFG_SECTION_LIMIT, '0);
                write_default(CFG_BLOCKED_STREAMS, '0);
                write_default(CFG_CONNECT, '0);
                write_default(CFG_DATAGRAM, '0);
            end else begin
                write_default(CFG_TABLE_CAPACITY, rand_fit(2'($urandom_range(0, 3))));
                write_default(CFG_SECTION_LIMIT, rand_fit(2'($urandom_range(0, 3))));
                write_default(CFG_BLOCKED_STREAMS, rand_fit(2'($urandom_range(0, 3))));
                write_default(CFG_CONNECT, VAL_W'($urandom_range(0, 1)));
                write_default(CFG_DATAGRAM, VAL_W'($urandom_range(0, 1)));
            end
            // An index past the last register must leave every default alone.
            if (p == 3)
                write_default(CFG_IDX_W'(CFG_DATAGRAM + $urandom_range(1, 3)),
                              VAL_W'({$urandom, $urandom}));
            @(negedge i_clk);
            if (p == 4) begin
                // Long hold on the output while end words keep coming.
                hold_go = 1'b1;
                send_gaps = 1'b0;
                repeat (40) begin
                    if ($urandom_range(0, 3) == 0)
                        push_payload();
                    else
                        push_end();
                end
            end
            if (p == 5) begin
                send_gaps = 1'b0;
                recv_gaps = 1'b0;
            end
            phase_end = words_pushed + PHASE_WORDS;
            while (words_pushed < phase_end)
                push_payload();
            wait_idle();
            send_gaps = 1'b1;
            recv_gaps = 1'b1;
        end

        // Broken payload last, since the error stays set until reset.
        repeat ($urandom_range(0, 3))
            push_pair();
        case ($urandom_range(0, 2))
            0: begin
                code = 2'($urandom_range(1, 3));
                push_varint(rand_fit(code), code, $urandom_range(1, (1 << code) - 1));
            end
            1: begin
                push_any(rand_id());
                code = 2'($urandom_range(1, 3));
                push_varint(rand_fit(code), code, $urandom_range(1, (1 << code) - 1));
            end
            default: push_any(rand_id());
        endcase
        push_end();
        repeat (120) begin
            if ($urandom_range(0, 3) == 0)
                push_end();
            else
                push_word(KIND_BYTE, BYTE_W'($urandom));
        end
        repeat (5)
            push_payload();
        wait_idle();

        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
